// File: design/rbmd_pkg.sv
// ----------------------------------------------------------------------------
// rbmd_pkg
// Shared types and constants for the RGBA 2x2 box mipmap downsampler.
// ----------------------------------------------------------------------------
package rbmd_pkg;

	localparam int NUM_CHAN = 4;
	localparam int CHAN_W   = 8;
	localparam int PAIR_W   = CHAN_W + 1;
	localparam int QUAD_W   = CHAN_W + 2;
	localparam int LINE_W   = NUM_CHAN * PAIR_W;
	localparam int SIZE_W   = 4;

	// Configuration register indexes
	localparam logic REG_WIDTH_LOG2  = 1'b0;
	localparam logic REG_HEIGHT_LOG2 = 1'b1;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
	typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_sum_t;

	typedef struct packed {
		logic emit;       // this transfer closes a 2x2 block
		logic use_line;   // vertical partner comes from the line store
		logic row_end;
		logic image_end;
	} ctl_t;

endpackage

// File: design/rbmd_line_mem.sv
// ----------------------------------------------------------------------------
// rbmd_line_mem
// Line store of horizontal pair sums, one entry per output column.
// Single address, synchronous write, registered read with enable.
// ----------------------------------------------------------------------------
module rbmd_line_mem #(
	parameter int ADDR_W = 10
) (
	input  logic                       clk,
	input  logic [ADDR_W-1:0]          addr,
	input  logic                       wr_en,
	input  rbmd_pkg::pair_sum_t        wr_data,
	input  logic                       rd_en,
	output rbmd_pkg::pair_sum_t        rd_data
);

	rbmd_pkg::pair_sum_t mem [0:(1 << ADDR_W)-1];
	rbmd_pkg::pair_sum_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	// hold the read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/rbmd_front.sv
// ----------------------------------------------------------------------------
// rbmd_front
// Size registers, raster counters, held even-column pixel and horizontal
// pair sum. Decides per transfer whether to store, fetch or emit.
// ----------------------------------------------------------------------------
module rbmd_front #(
	parameter int MAX_WIDTH_LOG2 = 11,
	parameter int ADDR_W         = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_index,
	input  logic [rbmd_pkg::SIZE_W-1:0]       cfg_data,
	input  logic                              accept,
	input  rbmd_pkg::pixel_t                  pix,
	output rbmd_pkg::pair_sum_t               pair_sum,
	output rbmd_pkg::ctl_t                    ctl,
	output logic [ADDR_W-1:0]                 line_addr,
	output logic                              line_wr_en,
	output logic                              line_rd_en
);

	localparam int CNT_W = MAX_WIDTH_LOG2;
	localparam logic [rbmd_pkg::SIZE_W-1:0] MAX_L2 = rbmd_pkg::SIZE_W'(MAX_WIDTH_LOG2);

	logic [rbmd_pkg::SIZE_W-1:0] width_log2_q, height_log2_q;
	logic [rbmd_pkg::SIZE_W-1:0] wl_eff, hl_eff;
	logic [CNT_W-1:0]            column_q, row_q;
	logic [CNT_W-1:0]            wmask, hmask, col, row;
	logic                        col_last, row_last, wide, tall, pair_done;
	rbmd_pkg::pixel_t            held_q;

	// saturate sizes above the supported maximum
	assign wl_eff = (width_log2_q > MAX_L2) ? MAX_L2 : width_log2_q;
	assign hl_eff = (height_log2_q > MAX_L2) ? MAX_L2 : height_log2_q;

	assign wmask = ~({CNT_W{1'b1}} << wl_eff);
	assign hmask = ~({CNT_W{1'b1}} << hl_eff);
	assign col   = column_q & wmask;
	assign row   = row_q & hmask;

	assign col_last  = (col == wmask);
	assign row_last  = (row == hmask);
	assign wide      = (wl_eff != '0);
	assign tall      = (hl_eff != '0);
	assign pair_done = !wide || col[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= '0;
			height_log2_q <= '0;
			column_q      <= '0;
			row_q         <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == rbmd_pkg::REG_WIDTH_LOG2) begin
				width_log2_q <= cfg_data;
			end else begin
				height_log2_q <= cfg_data;
			end
			// restart the image at its first pixel
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (col_last) begin
				column_q <= '0;
				row_q    <= row_last ? '0 : row + 1'b1;
			end else begin
				column_q <= col + 1'b1;
				row_q    <= row;
			end
		end
	end

	// hold the even-column pixel until its partner arrives
	always_ff @(posedge clk) begin
		if (accept && wide && !col[0]) begin
			held_q <= pix;
		end
	end

	always_comb begin
		for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++) begin
			if (wide) begin
				pair_sum[c] = {1'b0, held_q[c]} + {1'b0, pix[c]};
			end else begin
				pair_sum[c] = {pix[c], 1'b0};
			end
		end
	end

	assign line_addr  = ADDR_W'(col >> 1);
	assign line_wr_en = accept && pair_done && tall && !row[0];
	assign line_rd_en = accept && pair_done && tall && row[0];

	assign ctl.emit      = pair_done && (!tall || row[0]);
	assign ctl.use_line  = tall;
	assign ctl.row_end   = col_last;
	assign ctl.image_end = col_last && row_last;

endmodule

// File: design/rgba_box_mipmap_downsampler.sv
// ----------------------------------------------------------------------------
// rgba_box_mipmap_downsampler
// 2x2 box filter over a raster stream of RGBA8 pixels: one mipmap level down.
// ----------------------------------------------------------------------------
// Path: the transfer of the pixel that closes a 2x2 block loads stage 1
//   and the line store read; out_valid rises when the output register
//   then loads from stage 1, which waits while the output is stalled.
// Throughput: one source pixel per cycle unless the output stalls; in tall
//   images, one line store access per pair: even rows write, odd rows read.
// Reset: sizes return to zero (1x1 image), counters and pipeline valids
//   clear; the line store is not cleared, every entry is written by an even
//   row before the odd row below reads it.
// ----------------------------------------------------------------------------
module rgba_box_mipmap_downsampler #(
	parameter int MAX_WIDTH_LOG2 = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic                          cfg_index,
	input  logic [rbmd_pkg::SIZE_W-1:0]   cfg_data,
	// source pixels
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rbmd_pkg::CHAN_W-1:0]   chan0,
	input  logic [rbmd_pkg::CHAN_W-1:0]   chan1,
	input  logic [rbmd_pkg::CHAN_W-1:0]   chan2,
	input  logic [rbmd_pkg::CHAN_W-1:0]   chan3,
	// downsampled pixels
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rbmd_pkg::CHAN_W-1:0]   avg0,
	output logic [rbmd_pkg::CHAN_W-1:0]   avg1,
	output logic [rbmd_pkg::CHAN_W-1:0]   avg2,
	output logic [rbmd_pkg::CHAN_W-1:0]   avg3,
	output logic                          row_end,
	output logic                          image_end
);

	// One line store entry per output column; keep at least one address bit.
	localparam int ADDR_W = (MAX_WIDTH_LOG2 > 1) ? MAX_WIDTH_LOG2 - 1 : 1;

	logic                  accept;
	rbmd_pkg::pixel_t      pix;
	rbmd_pkg::pair_sum_t   pair_sum;
	rbmd_pkg::ctl_t        ctl;
	logic [ADDR_W-1:0]     line_addr;
	logic                  line_wr_en, line_rd_en;
	rbmd_pkg::pair_sum_t   line_rd_data;

	// stage 1: pair sum waits beside the line store read
	logic                  valid_s1;
	rbmd_pkg::ctl_t        ctl_s1;
	rbmd_pkg::pair_sum_t   pair_sum_s1;
	logic                  move_s1;

	// output register
	logic                  out_valid_q;
	rbmd_pkg::pixel_t      avg_q;
	logic                  row_end_q, image_end_q;
	rbmd_pkg::pixel_t      avg_s1;

	assign pix = {chan3, chan2, chan1, chan0};

	// Stage 1 moves on whenever the output register is empty or being drained,
	// so a new pixel is taken even while a finished result still waits.
	assign move_s1  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || move_s1;
	assign accept   = in_valid && in_ready;

	rbmd_front #(
		.MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2),
		.ADDR_W         (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.pix        (pix),
		.pair_sum   (pair_sum),
		.ctl        (ctl),
		.line_addr  (line_addr),
		.line_wr_en (line_wr_en),
		.line_rd_en (line_rd_en)
	);

	// The read data register only loads on a transfer, so it holds through
	// a stall together with stage 1.
	rbmd_line_mem #(
		.ADDR_W (ADDR_W)
	) u_line_mem (
		.clk     (clk),
		.addr    (line_addr),
		.wr_en   (line_wr_en),
		.wr_data (pair_sum),
		.rd_en   (line_rd_en),
		.rd_data (line_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1      <= ctl;
			pair_sum_s1 <= pair_sum;
		end
	end

	// Vertical sum: stored pair from the row above, or the pair doubled
	// when the image is a single row tall. Divide by four by dropping two bits.
	always_comb begin
		logic [rbmd_pkg::QUAD_W-1:0] quad;
		for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++) begin
			if (ctl_s1.use_line) begin
				quad = {1'b0, line_rd_data[c]} + {1'b0, pair_sum_s1[c]};
			end else begin
				quad = {pair_sum_s1[c], 1'b0};
			end
			avg_s1[c] = quad[rbmd_pkg::QUAD_W-1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && valid_s1) begin
			avg_q       <= avg_s1;
			row_end_q   <= ctl_s1.row_end;
			image_end_q <= ctl_s1.image_end;
		end
	end

	assign out_valid = out_valid_q;
	assign avg0      = avg_q[0];
	assign avg1      = avg_q[1];
	assign avg2      = avg_q[2];
	assign avg3      = avg_q[3];
	assign row_end   = row_end_q;
	assign image_end = image_end_q;

endmodule

// File: verif/rgba_box_mipmap_downsampler_test.sv
// ----------------------------------------------------------------------------
// rgba_box_mipmap_downsampler_test
// Self-checking bench for the 2x2 box mipmap downsampler. A queue-fed driver
// streams source texels under random valid gaps, and an in-bench box filter
// predicts each downsampled pixel. A monitor with random ready stalls checks
// every output transfer field by field. Image sizes change only between
// phases, once the block has drained.
// ----------------------------------------------------------------------------
module rgba_box_mipmap_downsampler_test;

	localparam int MAX_LOG2   = 11;
	localparam int LINE_SLOTS = 1 << (MAX_LOG2 - 1);

	// One downsampled pixel as it leaves the block
	typedef struct packed {
		rbmd_pkg::pixel_t avg;
		logic             row_end;
		logic             image_end;
	} mip_px_t;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic                          cfg_index = rbmd_pkg::REG_WIDTH_LOG2;
	logic [rbmd_pkg::SIZE_W-1:0]   cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic [rbmd_pkg::CHAN_W-1:0]   chan0     = '0;
	logic [rbmd_pkg::CHAN_W-1:0]   chan1     = '0;
	logic [rbmd_pkg::CHAN_W-1:0]   chan2     = '0;
	logic [rbmd_pkg::CHAN_W-1:0]   chan3     = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [rbmd_pkg::CHAN_W-1:0]   avg0;
	logic [rbmd_pkg::CHAN_W-1:0]   avg1;
	logic [rbmd_pkg::CHAN_W-1:0]   avg2;
	logic [rbmd_pkg::CHAN_W-1:0]   avg3;
	logic                          row_end;
	logic                          image_end;

	rgba_box_mipmap_downsampler #(
		.MAX_WIDTH_LOG2(MAX_LOG2)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.chan0    (chan0),
		.chan1    (chan1),
		.chan2    (chan2),
		.chan3    (chan3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.avg0     (avg0),
		.avg1     (avg1),
		.avg2     (avg2),
		.avg3     (avg3),
		.row_end  (row_end),
		.image_end(image_end)
	);

	// ------------------------------------------------------------------------
	// Box filter shadow state: sizes, raster position, held even-column texel
	// and the line of horizontal pair sums left by the last even row.
	// ------------------------------------------------------------------------
	logic [rbmd_pkg::SIZE_W-1:0] sz_wl = '0;
	logic [rbmd_pkg::SIZE_W-1:0] sz_hl = '0;
	logic [MAX_LOG2-1:0]         src_col = '0;
	logic [MAX_LOG2-1:0]         src_row = '0;
	rbmd_pkg::pixel_t            held_px = '0;
	rbmd_pkg::pair_sum_t         pair_line [LINE_SLOTS];

	rbmd_pkg::pixel_t texel_queue [$];   // source texels waiting for the driver
	mip_px_t          mip_due [$];       // downsampled pixels still owed by the block

	rbmd_pkg::pixel_t cur_texel = '0;
	bit     texel_held     = 1'b0;
	int     gap_left       = 0;
	int     stall_left     = 0;
	bit     sender_steady  = 1'b0;
	bit     receiver_steady = 1'b0;

	int n_errors  = 0;
	int n_texels  = 0;
	int n_checked = 0;
	int n_writes  = 0;

	// Advance the shadow filter by one source texel; return 1 when the texel
	// closes a 2x2 block and fill in the pixel the block must emit.
	function automatic bit box_reduce(input rbmd_pkg::pixel_t px, output mip_px_t res);
		int unsigned                   wl;
		int unsigned                   hl;
		logic [MAX_LOG2-1:0]           wmask;
		logic [MAX_LOG2-1:0]           hmask;
		logic [MAX_LOG2-1:0]           col;
		logic [MAX_LOG2-1:0]           row;
		logic [MAX_LOG2-2:0]           slot;
		rbmd_pkg::pair_sum_t           hsum;
		logic [rbmd_pkg::QUAD_W-1:0]   quad;
		res = '0;
		// Sizes above the supported maximum saturate
		wl = (sz_wl > MAX_LOG2) ? MAX_LOG2 : sz_wl;
		hl = (sz_hl > MAX_LOG2) ? MAX_LOG2 : sz_hl;
		wmask = MAX_LOG2'((32'd1 << wl) - 1);
		hmask = MAX_LOG2'((32'd1 << hl) - 1);
		col = src_col & wmask;
		row = src_row & hmask;

		// Step the raster position; wrap to a fresh image at the end
		if (col == wmask) begin
			src_col = '0;
			src_row = (row == hmask) ? '0 : row + 1'b1;
		end else begin
			src_col = col + 1'b1;
			src_row = row;
		end

		// Horizontal pair: a 1-wide image pairs each texel with itself
		if (wl == 0) begin
			for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++)
				hsum[c] = {px[c], 1'b0};
		end else if (!col[0]) begin
			held_px = px;
			return 1'b0;
		end else begin
			for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++)
				hsum[c] = {1'b0, held_px[c]} + {1'b0, px[c]};
		end

		// Vertical pair: a 1-tall image pairs each row with itself
		slot = col[MAX_LOG2-1:1];
		if (hl == 0) begin
			for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++) begin
				quad = {hsum[c], 1'b0};
				res.avg[c] = quad[rbmd_pkg::QUAD_W-1:2];
			end
		end else if (!row[0]) begin
			pair_line[slot] = hsum;
			return 1'b0;
		end else begin
			for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++) begin
				quad = {1'b0, pair_line[slot][c]} + {1'b0, hsum[c]};
				res.avg[c] = quad[rbmd_pkg::QUAD_W-1:2];
			end
		end

		res.row_end   = (col == wmask);
		res.image_end = (col == wmask) && (row == hmask);
		return 1'b1;
	endfunction

	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// Random texel; some channels pinned to 0 or 255 to hit carry extremes
	function automatic rbmd_pkg::pixel_t random_texel();
		rbmd_pkg::pixel_t px;
		for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++) begin
			case ($urandom_range(0, 9))
				0: px[c] = '0;
				1: px[c] = '1;
				default: px[c] = rbmd_pkg::CHAN_W'($urandom_range(0, 255));
			endcase
		end
		return px;
	endfunction

	// Mostly small sizes, sometimes medium, rarely large or past the maximum
	function automatic logic [rbmd_pkg::SIZE_W-1:0] pick_log2();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return rbmd_pkg::SIZE_W'($urandom_range(0, 3));
		if (r < 92)
			return rbmd_pkg::SIZE_W'($urandom_range(4, 7));
		return rbmd_pkg::SIZE_W'($urandom_range(8, 15));
	endfunction

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: pop the next texel after its gap, hold valid and payload until
	// the transfer, then run the shadow filter on what was transferred.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		mip_px_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
			texel_held = 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (box_reduce(cur_texel, res))
					mip_due.push_back(res);
				texel_held = 1'b0;
				n_texels++;
				gap_left = pick_gap(sender_steady);
			end
			if (!texel_held) begin
				if (gap_left > 0)
					gap_left--;
				else if (texel_queue.size() != 0) begin
					cur_texel = texel_queue.pop_front();
					texel_held = 1'b1;
				end
			end
			// One assignment per edge: a back-to-back texel keeps valid high
			in_valid <= texel_held;
			chan0 <= cur_texel[0];
			chan1 <= cur_texel[1];
			chan2 <= cur_texel[2];
			chan3 <= cur_texel[3];
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each output transfer against the oldest owed pixel, then
	// decide ready for the next edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rbmd_pkg::pixel_t got;
		mip_px_t          want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {avg3, avg2, avg1, avg0};
				n_checked++;
				if (mip_due.size() == 0) begin
					$error("output transfer with no pixel owed: avg %h row_end %b image_end %b",
						got, row_end, image_end);
					n_errors++;
				end else begin
					want = mip_due.pop_front();
					for (int c = 0; c < rbmd_pkg::NUM_CHAN; c++) begin
						if (got[c] !== want.avg[c]) begin
							$error("avg%0d: expected %0d, actual %0d", c, want.avg[c], got[c]);
							n_errors++;
						end
					end
					if (row_end !== want.row_end) begin
						$error("row_end: expected %b, actual %b", want.row_end, row_end);
						n_errors++;
					end
					if (image_end !== want.image_end) begin
						$error("image_end: expected %b, actual %b", want.image_end, image_end);
						n_errors++;
					end
				end
			end
			// Stall: mostly a short one, sometimes a long hold
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!receiver_steady && $urandom_range(0, 7) == 0) begin
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
					: $urandom_range(5, 23);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Wait until every texel is transferred and every owed pixel has left,
	// then let the pipeline flush texels that emit nothing.
	task automatic settle();
		do
			@(posedge clk);
		while (texel_queue.size() != 0 || texel_held || mip_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write one size register; the block restarts its image on any write
	task automatic write_reg(input logic idx, input logic [rbmd_pkg::SIZE_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == rbmd_pkg::REG_WIDTH_LOG2)
			sz_wl = val;
		else
			sz_hl = val;
		src_col = '0;
		src_row = '0;
		n_writes++;
	endtask

	// Drain, then write both sizes in random order
	task automatic set_sizes(input logic [rbmd_pkg::SIZE_W-1:0] wl,
			input logic [rbmd_pkg::SIZE_W-1:0] hl);
		settle();
		if ($urandom_range(0, 1)) begin
			write_reg(rbmd_pkg::REG_WIDTH_LOG2, wl);
			write_reg(rbmd_pkg::REG_HEIGHT_LOG2, hl);
		end else begin
			write_reg(rbmd_pkg::REG_HEIGHT_LOG2, hl);
			write_reg(rbmd_pkg::REG_WIDTH_LOG2, wl);
		end
	endtask

	task automatic push_random(input int n);
		repeat (n) texel_queue.push_back(random_texel());
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int          n_random;
		int          n;
		int          area;
		int unsigned ew;
		int unsigned eh;
		logic [rbmd_pkg::SIZE_W-1:0] wl;
		logic [rbmd_pkg::SIZE_W-1:0] hl;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 1x1 straight out of reset: every texel is its own block
		texel_queue.push_back('0);
		texel_queue.push_back('1);
		texel_queue.push_back({8'hfe, 8'h7f, 8'h80, 8'h01});

		// 2x2, two images back to back: all-ones, then sums that truncate
		set_sizes(4'd1, 4'd1);
		repeat (4) texel_queue.push_back('1);
		texel_queue.push_back({8'h01, 8'hff, 8'h00, 8'h03});
		texel_queue.push_back({8'h01, 8'hff, 8'h00, 8'h00});
		texel_queue.push_back({8'h01, 8'hff, 8'h00, 8'h00});
		texel_queue.push_back({8'h00, 8'hfe, 8'h01, 8'h00});

		// 1-wide column: texel doubles as its horizontal partner
		set_sizes(4'd0, 4'd1);
		push_random(4);

		// 1-tall row: each row doubles as its vertical partner
		set_sizes(4'd1, 4'd0);
		push_random(4);

		// Abandon a 4x2 image partway, rewrite the height, start over
		set_sizes(4'd2, 4'd1);
		push_random(3);
		settle();
		write_reg(rbmd_pkg::REG_HEIGHT_LOG2, 4'd1);
		push_random(8);

		// Tallest column the block supports
		set_sizes(4'd0, 4'd11);
		push_random(40);

		// Width past the maximum on a single-row image: each pair emits
		set_sizes(4'd14, 4'd0);
		sender_steady = $urandom_range(0, 1);
		push_random(64);

		// Both sizes past the maximum
		set_sizes(4'd15, 4'd12);
		sender_steady = 1'b0;
		push_random(48);

		// Random phases: random sizes, whole images mostly, some cut short
		n_random = 0;
		while (n_random < 450) begin
			wl = pick_log2();
			hl = pick_log2();
			ew = (wl > MAX_LOG2) ? MAX_LOG2 : wl;
			eh = (hl > MAX_LOG2) ? MAX_LOG2 : hl;
			area = 1 << (ew + eh);
			if (area <= 64) begin
				n = area * $urandom_range(1, 3);
				if ($urandom_range(0, 2) == 0)
					n += $urandom_range(1, area);
			end else begin
				n = $urandom_range(8, 96);
			end
			set_sizes(wl, hl);
			sender_steady   = ($urandom_range(0, 3) == 0);
			receiver_steady = ($urandom_range(0, 3) == 0);
			push_random(n);
			n_random += n;
		end

		// Drain and leave time for anything the block should not send
		do
			@(posedge clk);
		while (texel_queue.size() != 0 || texel_held || mip_due.size() != 0);
		repeat (10) @(posedge clk);
		if (mip_due.size() != 0) begin
			$error("%0d downsampled pixels never arrived", mip_due.size());
			n_errors++;
		end

		$display("Streamed %0d source texels through %0d size writes,", n_texels, n_writes);
		$display("checked %0d downsampled pixels, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("rgba_box_mipmap_downsampler_test: done, clean");
		end else begin
			$display("rgba_box_mipmap_downsampler_test: done, errors");
		end
		$finish;
	end

	// Watchdog: well past the slowest legal run
	initial begin
		#15000000;
		$display("rgba_box_mipmap_downsampler_test: done, errors");
		$finish;
	end

endmodule
